[hdl/assert_macros.svh]
// Assertion macros for the RTL files.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Implication with a fixed delay, checked outside reset.
`define ASSERT_DELAYED(label, ante, dly, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##dly (cons)) \
		else $error(msg);

`endif

[hdl/tps_pkg.sv]
// ----------------------------------------------------------------------------
// tps_pkg
// Shared constants for the triangle pixel shader: default widths, register
// indexes and fixed field sizes.
// ----------------------------------------------------------------------------
package tps_pkg;

	// Default coordinate width and weight fraction width.
	localparam int COORD_BITS_DEF    = 12;
	localparam int FRACTION_BITS_DEF = 16;

	// Fixed field widths.
	localparam int COLOR_BITS     = 24;
	localparam int ADDR_BITS      = 24;
	localparam int KEY_BITS       = 32;
	localparam int DIM_BITS       = 13;
	localparam int CFG_INDEX_BITS = 4;
	localparam int CFG_DATA_BITS  = 32;

	// Register indexes of the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_V0_POS   = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_V1_POS   = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_V2_POS   = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_V0_COLOR = 4'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_V1_COLOR = 4'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_V2_COLOR = 4'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN   = 4'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_KEY      = 4'd7;

endpackage

[hdl/triangle_pixel_shader.sv]
// ----------------------------------------------------------------------------
// triangle_pixel_shader
// Coverage test and two-step Gouraud blend of one configured triangle,
// one pixel coordinate per cycle, with a pipelined restoring divider.
// ----------------------------------------------------------------------------
//
// Channel   Signals                                  Direction
// pixel     start, busy, pixel_x, pixel_y             in (busy out)
// result    done, covered, write_enable,              out
//           pixel_address, pixel_color
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A pixel is taken in every cycle; busy stays low.
// The pipeline has three front stages (pixel capture, edge and cross
// products, coverage), one divider stage per weight bit, two blend stages
// and the output register. Reset clears the configuration, the area
// registers, the valid bits and the outputs; pipeline data registers keep
// their contents. Nothing stalls; each result shows for one cycle with done.
//
`include "assert_macros.svh"

module triangle_pixel_shader #(
	parameter int COORD_BITS    = tps_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = tps_pkg::FRACTION_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [COORD_BITS-1:0]         pixel_x,
	input  logic signed [COORD_BITS-1:0]         pixel_y,
	output logic                                 done,
	output logic                                 covered,
	output logic                                 write_enable,
	output logic [tps_pkg::ADDR_BITS-1:0]        pixel_address,
	output logic [tps_pkg::COLOR_BITS-1:0]       pixel_color,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [tps_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [tps_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

	localparam int CB  = COORD_BITS;
	localparam int FB  = FRACTION_BITS;
	localparam int EW  = CB + 1;
	localparam int PW  = 2 * EW;
	localparam int DW  = PW + 1;
	localparam int RW  = DW;
	localparam int CW  = tps_pkg::COLOR_BITS;
	localparam int AW  = tps_pkg::ADDR_BITS;
	localparam int KW  = tps_pkg::KEY_BITS;
	localparam int SW  = tps_pkg::DIM_BITS;
	localparam int LAT = FB + 6;

	// Configuration registers.
	logic [2*CB-1:0] v0_pos_q, v1_pos_q, v2_pos_q;
	logic [CW-1:0]   v0_col_q, v1_col_q, v2_col_q;
	logic [2*SW-1:0] screen_q;
	logic [KW-1:0]   key_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	// Configuration write transactions; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v0_pos_q <= '0;
			v1_pos_q <= '0;
			v2_pos_q <= '0;
			v0_col_q <= '0;
			v1_col_q <= '0;
			v2_col_q <= '0;
			screen_q <= '0;
			key_q    <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				tps_pkg::REG_V0_POS:   v0_pos_q <= cfg_data[2*CB-1:0];
				tps_pkg::REG_V1_POS:   v1_pos_q <= cfg_data[2*CB-1:0];
				tps_pkg::REG_V2_POS:   v2_pos_q <= cfg_data[2*CB-1:0];
				tps_pkg::REG_V0_COLOR: v0_col_q <= cfg_data[CW-1:0];
				tps_pkg::REG_V1_COLOR: v1_col_q <= cfg_data[CW-1:0];
				tps_pkg::REG_V2_COLOR: v2_col_q <= cfg_data[CW-1:0];
				tps_pkg::REG_SCREEN:   screen_q <= cfg_data[2*SW-1:0];
				tps_pkg::REG_KEY:      key_q    <= cfg_data[KW-1:0];
				default: ;
			endcase
		end
	end

	// Vertex coordinates and the two fixed edges.
	logic signed [CB-1:0] ax, ay, bx, by, cx, cy;
	logic signed [EW-1:0] e0x, e0y, e1x, e1y;

	assign ax  = v0_pos_q[CB-1:0];
	assign ay  = v0_pos_q[2*CB-1:CB];
	assign bx  = v1_pos_q[CB-1:0];
	assign by  = v1_pos_q[2*CB-1:CB];
	assign cx  = v2_pos_q[CB-1:0];
	assign cy  = v2_pos_q[2*CB-1:CB];
	assign e0x = EW'(bx) - EW'(ax);
	assign e0y = EW'(by) - EW'(ay);
	assign e1x = EW'(cx) - EW'(ax);
	assign e1y = EW'(cy) - EW'(ay);

	// Twice the signed area, settled over two registers after a write.
	logic signed [PW-1:0] dpa_q, dpb_q;
	logic signed [DW-1:0] d_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dpa_q <= '0;
			dpb_q <= '0;
			d_q   <= '0;
		end else begin
			dpa_q <= e0x * e1y;
			dpb_q <= e0y * e1x;
			d_q   <= DW'(dpa_q) - DW'(dpb_q);
		end
	end

	// Stage 1: capture the pixel.
	logic                 v_s1;
	logic signed [CB-1:0] px_s1, py_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= pixel_x;
		py_s1 <= pixel_y;
	end

	// Stage 2: pixel edge and the four cross-product terms.
	logic signed [EW-1:0] e2x, e2y;
	logic                 v_s2;
	logic signed [CB-1:0] px_s2, py_s2;
	logic signed [PW-1:0] vna_s2, vnb_s2, wna_s2, wnb_s2;

	assign e2x = EW'(px_s1) - EW'(ax);
	assign e2y = EW'(py_s1) - EW'(ay);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s2  <= px_s1;
		py_s2  <= py_s1;
		vna_s2 <= e2x * e1y;
		vnb_s2 <= e2y * e1x;
		wna_s2 <= e0x * e2y;
		wnb_s2 <= e0y * e2x;
	end

	// Stage 3: orient so the area is positive and test strict coverage.
	logic signed [DW-1:0] vn, wn, vn_o, wn_o, d_o;
	logic signed [DW:0]   vw_sum;
	logic                 in_tri;
	logic                 v_s3, cov_s3;
	logic signed [CB-1:0] px_s3, py_s3;
	logic [RW-1:0]        rv_s3, rw_s3, d_s3;

	always_comb begin
		vn     = DW'(vna_s2) - DW'(vnb_s2);
		wn     = DW'(wna_s2) - DW'(wnb_s2);
		vn_o   = d_q[DW-1] ? -vn : vn;
		wn_o   = d_q[DW-1] ? -wn : wn;
		d_o    = d_q[DW-1] ? -d_q : d_q;
		vw_sum = (DW+1)'(vn_o) + (DW+1)'(wn_o);
		in_tri = (d_o != '0) && (vn_o > 0) && (wn_o > 0) && (vw_sum < (DW+1)'(d_o));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	// Numerators are zeroed when outside so the divider stays in range.
	always_ff @(posedge clk) begin
		px_s3  <= px_s2;
		py_s3  <= py_s2;
		cov_s3 <= in_tri;
		rv_s3  <= in_tri ? RW'(vn_o) : '0;
		rw_s3  <= in_tri ? RW'(wn_o) : '0;
		d_s3   <= in_tri ? RW'(d_o) : {{(RW-1){1'b0}}, 1'b1};
	end

	// One restoring division step: returns the quotient bit and new remainder.
	function automatic logic [RW:0] div_step(input logic [RW-1:0] r, input logic [RW-1:0] d);
		logic [RW:0] sh;
		logic [RW:0] diff;
		sh   = {r, 1'b0};
		diff = sh - {1'b0, d};
		if (sh >= {1'b0, d}) begin
			div_step = {1'b1, diff[RW-1:0]};
		end else begin
			div_step = {1'b0, sh[RW-1:0]};
		end
	endfunction

	// Divider stages: one weight bit per stage for both v and w.
	logic                 div_v_s   [FB];
	logic                 div_cov_s [FB];
	logic signed [CB-1:0] div_px_s  [FB];
	logic signed [CB-1:0] div_py_s  [FB];
	logic [RW-1:0]        div_rv_s  [FB];
	logic [RW-1:0]        div_rw_s  [FB];
	logic [RW-1:0]        div_d_s   [FB];
	logic [FB-1:0]        div_qv_s  [FB];
	logic [FB-1:0]        div_qw_s  [FB];
	logic [RW:0]          step_v    [FB];
	logic [RW:0]          step_w    [FB];

	always_comb begin
		for (int k = 0; k < FB; k++) begin
			if (k == 0) begin
				step_v[k] = div_step(rv_s3, d_s3);
				step_w[k] = div_step(rw_s3, d_s3);
			end else begin
				step_v[k] = div_step(div_rv_s[k-1], div_d_s[k-1]);
				step_w[k] = div_step(div_rw_s[k-1], div_d_s[k-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FB; k++) begin
				div_v_s[k] <= 1'b0;
			end
		end else begin
			for (int k = 0; k < FB; k++) begin
				if (k == 0) begin
					div_v_s[k] <= v_s3;
				end else begin
					div_v_s[k] <= div_v_s[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < FB; k++) begin
			div_rv_s[k] <= step_v[k][RW-1:0];
			div_rw_s[k] <= step_w[k][RW-1:0];
			if (k == 0) begin
				div_cov_s[k] <= cov_s3;
				div_px_s[k]  <= px_s3;
				div_py_s[k]  <= py_s3;
				div_d_s[k]   <= d_s3;
				div_qv_s[k]  <= {{(FB-1){1'b0}}, step_v[k][RW]};
				div_qw_s[k]  <= {{(FB-1){1'b0}}, step_w[k][RW]};
			end else begin
				div_cov_s[k] <= div_cov_s[k-1];
				div_px_s[k]  <= div_px_s[k-1];
				div_py_s[k]  <= div_py_s[k-1];
				div_d_s[k]   <= div_d_s[k-1];
				div_qv_s[k]  <= {div_qv_s[k-1][FB-2:0], step_v[k][RW]};
				div_qw_s[k]  <= {div_qw_s[k-1][FB-2:0], step_w[k][RW]};
			end
		end
	end

	// Blend of one 8-bit channel: a + floor((b - a) * ratio / 2^F).
	function automatic logic [7:0] blend_ch(input logic [7:0] a, input logic [7:0] b,
			input logic [FB-1:0] ratio);
		logic signed [8:0]     delta;
		logic signed [FB+9:0]  prod;
		delta    = $signed({1'b0, b}) - $signed({1'b0, a});
		prod     = delta * $signed({1'b0, ratio});
		blend_ch = a + prod[FB+7:FB];
	endfunction

	function automatic logic [CW-1:0] blend(input logic [CW-1:0] ca, input logic [CW-1:0] cb,
			input logic [FB-1:0] ratio);
		blend = {blend_ch(ca[23:16], cb[23:16], ratio),
			blend_ch(ca[15:8], cb[15:8], ratio),
			blend_ch(ca[7:0], cb[7:0], ratio)};
	endfunction

	// Blend stage 1: colour0 toward colour1 by v; screen test and address.
	localparam int LAST = FB - 1;
	logic [SW-1:0]            scr_w, scr_h;
	logic [CB+SW-1:0]         addr_full;
	logic                     v_b1, cov_b1, on_b1;
	logic [CW-1:0]            col_b1;
	logic [FB-1:0]            qw_b1;
	logic [AW-1:0]            addr_b1;

	assign scr_w     = screen_q[SW-1:0];
	assign scr_h     = screen_q[2*SW-1:SW];
	assign addr_full = (CB+SW)'(div_py_s[LAST]) * (CB+SW)'(scr_w)
		+ (CB+SW)'(div_px_s[LAST]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
		end else begin
			v_b1 <= div_v_s[LAST];
		end
	end

	always_ff @(posedge clk) begin
		cov_b1  <= div_cov_s[LAST];
		col_b1  <= blend(v0_col_q, v1_col_q, div_qv_s[LAST]);
		qw_b1   <= div_qw_s[LAST];
		on_b1   <= !div_px_s[LAST][CB-1] && !div_py_s[LAST][CB-1]
			&& ((SW+CB)'(div_px_s[LAST]) < (SW+CB)'(scr_w))
			&& ((SW+CB)'(div_py_s[LAST]) < (SW+CB)'(scr_h));
		addr_b1 <= addr_full[AW-1:0];
	end

	// Blend stage 2: that result toward colour2 by w.
	logic          v_b2, cov_b2, on_b2;
	logic [CW-1:0] col_b2;
	logic [AW-1:0] addr_b2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b2 <= 1'b0;
		end else begin
			v_b2 <= v_b1;
		end
	end

	always_ff @(posedge clk) begin
		cov_b2  <= cov_b1;
		on_b2   <= on_b1;
		col_b2  <= blend(col_b1, v2_col_q, qw_b1);
		addr_b2 <= addr_b1;
	end

	// Output register: key compare and zeroing of unused fields.
	logic we_n;

	assign we_n = cov_b2 && on_b2 && (KW'(col_b2) != key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done          <= 1'b0;
			covered       <= 1'b0;
			write_enable  <= 1'b0;
			pixel_address <= '0;
			pixel_color   <= '0;
		end else begin
			done          <= v_b2;
			covered       <= v_b2 && cov_b2;
			write_enable  <= v_b2 && we_n;
			pixel_address <= we_n ? addr_b2 : '0;
			pixel_color   <= cov_b2 ? col_b2 : '0;
		end
	end

	// Checks on the result stream.
	`ASSERT_IMPLIES(a_we_needs_cov, write_enable, covered, "write without coverage")
	`ASSERT_IMPLIES(a_color_zero, done && !covered, pixel_color == '0, "color on uncovered pixel")
	`ASSERT_IMPLIES(a_addr_zero, done && !write_enable, pixel_address == '0, "address without write")
	`ASSERT_DELAYED(a_latency, start && !busy, LAT, done, "result missing after fixed latency")

endmodule
